[sv/lutp_pkg.sv]
// shared types and constants for the lut unused input pruner
// no dependencies
package lutp_pkg;

   localparam int MAX_INPUTS = 6;
   localparam int PAD_WIDTH = 4;
   localparam int TABLE_BITS = 64;

   typedef enum logic [1:0] {
      MODE_GENERIC  = 2'd0,
      MODE_PAD_FOUR = 2'd1,
      MODE_MIN_ONE  = 2'd2,
      MODE_RESERVED = 2'd3
   } mode_type;

   localparam logic [63:0] LOW_HALF_MASK [6] = '{
      64'h5555555555555555, 64'h3333333333333333, 64'h0F0F0F0F0F0F0F0F,
      64'h00FF00FF00FF00FF, 64'h0000FFFF0000FFFF, 64'h00000000FFFFFFFF
   };

   typedef struct packed {
      logic [63:0] table_bits;
      logic [2:0]  input_count;
      logic [5:0]  tied_mask;
      logic [5:0]  tied_values;
   } item_type;

   typedef struct packed {
      logic        changed;
      logic [63:0] new_table;
      logic [2:0]  new_count;
      logic [5:0]  kept_mask;
      logic [2:0]  pad_count;
      logic        becomes_constant;
      logic        constant_value;
   } result_type;

endpackage

[sv/lut_unused_input_pruner.sv]
// top level of the lut unused input pruner: input register, pruning logic, result register
// depends on lutp_pkg and lutp_prune
// Takes one lut cell per cycle and presents its pruned form on the result ports: the item
// is captured in an input register, one pass of combinational pruning logic runs, and
// the result lands in an output register. Both stages hold independently, so an item is
// accepted every cycle unless the result side stalls with both stages full. The mode
// (mode_ff) is written through csr_wr_en/csr_wr_data and should only change while no
// item is in flight.
module lut_unused_input_pruner (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_table_bits,
   input  logic [2:0]  req_input_count,
   input  logic [5:0]  req_tied_mask,
   input  logic [5:0]  req_tied_values,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_changed,
   output logic [63:0] rsp_new_table,
   output logic [2:0]  rsp_new_count,
   output logic [5:0]  rsp_kept_mask,
   output logic [2:0]  rsp_pad_count,
   output logic        rsp_becomes_constant,
   output logic        rsp_constant_value
);

   lutp_pkg::mode_type   mode_ff, mode_in;
   logic                 s1_valid_ff, s1_valid_in;
   lutp_pkg::item_type   s1_item_ff, s1_item_in;
   logic                 s2_valid_ff, s2_valid_in;
   lutp_pkg::result_type s2_result_ff, s2_result_in;
   lutp_pkg::result_type result;
   logic                 s2_ready;
   logic                 s1_ready;
   logic                 s2_load;
   logic                 s1_load;

   lutp_prune u_prune (
      .item     (s1_item_ff),
      .mode_raw (mode_ff),
      .result   (result)
   );

   always_comb begin
      mode_in = csr_wr_en ? lutp_pkg::mode_type'(csr_wr_data) : mode_ff;
      s2_ready = !s2_valid_ff || !rsp_stall;
      s2_load = s1_valid_ff && s2_ready;
      s1_ready = !s1_valid_ff || s2_ready;
      s1_load = req_valid && s1_ready;
      s1_valid_in = s1_load || (s1_valid_ff && !s2_ready);
      s1_item_in = s1_load ? lutp_pkg::item_type'{table_bits: req_table_bits,
                                                  input_count: req_input_count,
                                                  tied_mask: req_tied_mask,
                                                  tied_values: req_tied_values}
                           : s1_item_ff;
      s2_valid_in = s2_load || (s2_valid_ff && rsp_stall);
      s2_result_in = s2_load ? result : s2_result_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= lutp_pkg::MODE_GENERIC;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
      s2_result_ff <= s2_result_in;
   end

   assign req_stall = !s1_ready;
   assign rsp_valid = s2_valid_ff;
   assign rsp_changed = s2_result_ff.changed;
   assign rsp_new_table = s2_result_ff.new_table;
   assign rsp_new_count = s2_result_ff.new_count;
   assign rsp_kept_mask = s2_result_ff.kept_mask;
   assign rsp_pad_count = s2_result_ff.pad_count;
   assign rsp_becomes_constant = s2_result_ff.becomes_constant;
   assign rsp_constant_value = s2_result_ff.constant_value;

endmodule

[sv/lutp_prune.sv]
// combinational pruning of one lut cell: dead input detection, packing, table rebuild
// depends on lutp_pkg
module lutp_prune (
   input  lutp_pkg::item_type   item,
   input  lutp_pkg::mode_type   mode_raw,
   output lutp_pkg::result_type result
);

   lutp_pkg::mode_type mode;
   logic [2:0]  n;
   logic [63:0] tmask;
   logic [63:0] t;
   logic [5:0]  dead;
   logic [5:0]  keep;
   logic [5:0]  fixed;
   logic [2:0]  pos [6];
   logic [2:0]  kept;
   logic [5:0]  kmask;
   logic        dirty;
   logic [2:0]  pad;
   logic [3:0]  sum;
   logic [2:0]  nc;
   logic [63:0] nt;
   logic [5:0]  lidx;
   logic [5:0]  idx_v;
   logic [3:0]  p;

   always_comb begin
      mode = (mode_raw == lutp_pkg::MODE_RESERVED) ? lutp_pkg::MODE_GENERIC : mode_raw;
      n = (item.input_count > 3'(lutp_pkg::MAX_INPUTS)) ?
          3'(lutp_pkg::MAX_INPUTS) : item.input_count;
      for (int k = 0; k < lutp_pkg::TABLE_BITS; k++) begin
         tmask[k] = ((7'(k) >> n) == 7'd0);
      end
      t = item.table_bits & tmask;

      for (int i = 0; i < 6; i++) begin
         dead[i] = ((t & lutp_pkg::LOW_HALF_MASK[i]) ==
                    ((t >> (1 << i)) & lutp_pkg::LOW_HALF_MASK[i]));
      end

      // classify each input
      kept = 3'd0;
      kmask = 6'd0;
      dirty = 1'b0;
      for (int i = 0; i < 6; i++) begin
         pos[i] = 3'd0;
         keep[i] = 1'b0;
         fixed[i] = 1'b0;
         if (3'(i) < n) begin
            if (item.tied_mask[i]) begin
               fixed[i] = item.tied_values[i];
               if (mode != lutp_pkg::MODE_PAD_FOUR) begin
                  dirty = 1'b1;
               end
            end else if (dead[i]) begin
               dirty = 1'b1;
            end else begin
               keep[i] = 1'b1;
               pos[i] = kept;
               kept = kept + 3'd1;
               kmask[i] = 1'b1;
            end
         end
      end

      pad = 3'd0;
      if (mode == lutp_pkg::MODE_PAD_FOUR && kept < 3'(lutp_pkg::PAD_WIDTH)) begin
         pad = 3'(lutp_pkg::PAD_WIDTH) - kept;
      end else if (mode == lutp_pkg::MODE_MIN_ONE && kept == 3'd0) begin
         pad = 3'd1;
      end
      sum = {1'b0, kept} + {1'b0, pad};
      nc = (sum > 4'd6) ? 3'd6 : sum[2:0];

      // rebuild the table over kept and pad inputs
      lidx = 6'd0;
      idx_v = 6'd0;
      p = 4'd0;
      for (int idx = 0; idx < lutp_pkg::TABLE_BITS; idx++) begin
         idx_v = 6'(idx);
         for (int i = 0; i < 6; i++) begin
            if (keep[i]) begin
               p = {1'b0, pos[i]} + {1'b0, pad};
               lidx[i] = (p < 4'd6) ? idx_v[p[2:0]] : 1'b0;
            end else begin
               lidx[i] = fixed[i];
            end
         end
         nt[idx] = ((7'(idx) >> nc) == 7'd0) ? t[lidx] : 1'b0;
      end

      if (!dirty) begin
         result.changed = 1'b0;
         result.new_table = t;
         result.new_count = n;
         result.kept_mask = 6'((7'd1 << n) - 7'd1);
         result.pad_count = 3'd0;
         result.becomes_constant = 1'b0;
         result.constant_value = 1'b0;
      end else begin
         result.changed = 1'b1;
         result.new_table = nt;
         result.new_count = nc;
         result.kept_mask = kmask;
         result.pad_count = pad;
         result.becomes_constant = (mode == lutp_pkg::MODE_GENERIC) && (nc == 3'd0);
         result.constant_value = (mode == lutp_pkg::MODE_GENERIC) && (nc == 3'd0) && nt[0];
      end
   end

endmodule
